// ----- rtl/core/tgsm_pkg.sv -----
// Package with the payload types, constants and divider status for the speed meter.
`timescale 1ns / 1ps

package tgsm_pkg;

  // Widths of the fields.
  localparam int unsigned CountFieldBits = 16;
  localparam int unsigned SpeedFieldBits = 16;
  localparam int unsigned DividendBits   = 32;
  localparam int unsigned OvfBits        = 16;

  // Defaults of the top-level parameters.
  localparam int unsigned CounterBitsDefault = 16;
  localparam int unsigned SpeedBitsDefault   = 16;

  // 0.02 m gate distance times a 10 MHz tick rate.
  localparam logic [DividendBits-1:0] DistanceRateReset = 32'd200000;

  localparam logic [OvfBits-1:0] OvfMax = '1;

  // Codes of the event_kind field.
  localparam logic EvOverflow = 1'b0;
  localparam logic EvCapture  = 1'b1;

  typedef struct packed {
    logic                      event_kind;
    logic [CountFieldBits-1:0] capture_count;
  } in_t;

  typedef struct packed {
    logic [SpeedFieldBits-1:0] speed;
    logic                      saturated;
  } out_t;

  // Status of the divider as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- rtl/core/tgsm_divider.sv -----
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module tgsm_divider #(
  parameter int unsigned TICK_BITS = tgsm_pkg::OvfBits + tgsm_pkg::CounterBitsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [tgsm_pkg::DividendBits-1:0]   dividend_i,
  input  logic [TICK_BITS-1:0]                divisor_i,
  output tgsm_pkg::div_stat_t                 stat_o,
  output logic [tgsm_pkg::DividendBits-1:0]   quotient_o
);

  localparam int unsigned QBits   = tgsm_pkg::DividendBits;
  localparam int unsigned RemBits = TICK_BITS + 1;
  localparam int unsigned CntBits = $clog2(QBits);
  localparam logic [CntBits-1:0] LastStep = CntBits'(QBits - 1);

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_e;

  div_state_e           state_q, state_d;
  logic [CntBits-1:0]   cnt_q, cnt_d;
  logic [RemBits-1:0]   rem_q, rem_d;
  logic [QBits-1:0]     quot_q, quot_d;
  logic [TICK_BITS-1:0] dsr_q, dsr_d;

  logic [RemBits-1:0] rem_sh;
  logic [RemBits-1:0] dsr_ext;
  logic               fits;

  // The dividend shifts out of the top of quot_q while quotient bits shift in.
  assign rem_sh  = {rem_q[RemBits-2:0], quot_q[QBits-1]};
  assign dsr_ext = {1'b0, dsr_q};
  assign fits    = (rem_sh >= dsr_ext);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quot_d  = quot_q;
    dsr_d   = dsr_q;
    case (state_q)
      DIV_RUN: begin
        rem_d  = fits ? (rem_sh - dsr_ext) : rem_sh;
        quot_d = {quot_q[QBits-2:0], fits};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == LastStep) begin
          state_d = DIV_DONE;
        end
      end
      DIV_DONE: begin
        state_d = DIV_IDLE;
      end
      default: begin
        state_d = DIV_IDLE;
      end
    endcase
    if (start_i) begin
      state_d = DIV_RUN;
      cnt_d   = '0;
      rem_d   = '0;
      quot_d  = dividend_i;
      dsr_d   = divisor_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      cnt_q   <= '0;
      rem_q   <= '0;
      quot_q  <= '0;
      dsr_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rem_q   <= rem_d;
      quot_q  <= quot_d;
      dsr_q   <= dsr_d;
    end
  end

  assign stat_o.busy = (state_q == DIV_RUN);
  assign stat_o.done = (state_q == DIV_DONE);
  assign quotient_o  = quot_q;

endmodule

// ----- rtl/core/two_gate_speed_meter.sv -----
// Top level of the two-gate speed meter: event sequencer, result register, assertions.
//
//   channel | direction | handshake                 | payload
//   in      | input     | in_valid_i / in_stall_o   | tgsm_pkg::in_t
//   out     | output    | out_valid_o / out_stall_i | tgsm_pkg::out_t
//   cfg     | input     | cfg_valid_i / cfg_ready_o | distance_times_rate, 32 bits
//
// An overflow or a first capture is taken while idle and leaves the input open.
// A second capture is accepted, then runs the 32 steps of the bit-serial
// divider, and the result register is loaded once the divider is done.
// The result waits in the divider while the output register is still full.
// Input is stalled from a second capture until its result is registered.
// Reset is asynchronous and active low; the dividend resets to 200000.
`timescale 1ns / 1ps

module two_gate_speed_meter #(
  parameter int unsigned COUNTER_BITS = tgsm_pkg::CounterBitsDefault,
  parameter int unsigned SPEED_BITS   = tgsm_pkg::SpeedBitsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  tgsm_pkg::in_t                     in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output tgsm_pkg::out_t                    out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tgsm_pkg::DividendBits-1:0] cfg_data_i
);

  localparam int unsigned TickBits = tgsm_pkg::OvfBits + COUNTER_BITS;
  localparam int unsigned QBits    = tgsm_pkg::DividendBits;
  localparam int unsigned LimBits  = (SPEED_BITS < tgsm_pkg::SpeedFieldBits) ?
                                     SPEED_BITS : tgsm_pkg::SpeedFieldBits;
  localparam logic [QBits-1:0] SpeedLimit = QBits'((64'd1 << LimBits) - 64'd1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_HOLD
  } state_e;

  state_e                            state_q;
  logic                              measuring_q;
  logic [tgsm_pkg::OvfBits-1:0]      ovf_q;
  logic [QBits-1:0]                  dtr_q;
  logic                              zero_ticks_q;
  logic                              out_valid_q;
  tgsm_pkg::out_t                    out_data_q;

  logic                in_accept;
  logic                second_cap;
  logic [COUNTER_BITS-1:0] cap_low;
  logic [TickBits-1:0] ticks;
  logic                slot_free;
  logic                load_result;
  logic                over_limit;
  tgsm_pkg::div_stat_t div_stat;
  logic [QBits-1:0]    quotient;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign second_cap = in_accept && (in_data_i.event_kind == tgsm_pkg::EvCapture) && measuring_q;
  // The cast masks a wide capture value and widens a narrow counter alike.
  assign cap_low    = COUNTER_BITS'(in_data_i.capture_count);
  assign ticks      = {ovf_q, cap_low};
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign load_result = ((state_q == ST_DIV && div_stat.done) || state_q == ST_HOLD) && slot_free;
  assign over_limit = zero_ticks_q || (quotient > SpeedLimit);

  tgsm_divider #(
    .TICK_BITS (TickBits)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (second_cap),
    .dividend_i (dtr_q),
    .divisor_i  (ticks),
    .stat_o     (div_stat),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      measuring_q  <= 1'b0;
      ovf_q        <= '0;
      dtr_q        <= tgsm_pkg::DistanceRateReset;
      zero_ticks_q <= 1'b0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
    end else begin
      if (cfg_valid_i) begin
        dtr_q <= cfg_data_i;
      end
      if (load_result) begin
        out_valid_q          <= 1'b1;
        out_data_q.speed     <= over_limit ? SpeedLimit[tgsm_pkg::SpeedFieldBits-1:0]
                                           : quotient[tgsm_pkg::SpeedFieldBits-1:0];
        out_data_q.saturated <= over_limit;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            if (in_data_i.event_kind == tgsm_pkg::EvOverflow) begin
              if (measuring_q && ovf_q != tgsm_pkg::OvfMax) begin
                ovf_q <= ovf_q + 1'b1;
              end
            end else if (!measuring_q) begin
              measuring_q <= 1'b1;
              ovf_q       <= '0;
            end else begin
              measuring_q  <= 1'b0;
              ovf_q        <= '0;
              zero_ticks_q <= (ticks == '0);
              state_q      <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            state_q <= load_result ? ST_IDLE : ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (load_result) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign cfg_ready_o = 1'b1;

`ifndef SYNTHESIS
  // No new request may come in while the divider is still working.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !div_stat.busy)
    else $error("input open while divider busy");

  // The divider only finishes for a measurement the sequencer is waiting on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> state_q == ST_DIV)
    else $error("divider done outside of divide state");

  // Overflows are never counted outside an armed measurement.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !measuring_q |-> ovf_q == '0)
    else $error("overflow count nonzero while idle");

  // A saturated result always carries the speed limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.saturated |->
      out_data_o.speed == SpeedLimit[tgsm_pkg::SpeedFieldBits-1:0])
    else $error("saturated result without limit value");
`endif

endmodule
